>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on clk and disabled while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion clocked on clk that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/mks_pkg.sv
package mks_pkg;

  localparam int CountBits = 16;
  localparam int WaitBits = 16;
  localparam int CmpBits = ((CountBits > WaitBits) ? CountBits : WaitBits) + 1;
  localparam int RowKeysBits = 32;
  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits = 32;

  typedef logic [CfgIndexBits-1:0] cfg_index_t;

  localparam cfg_index_t RegFirstWait = 3'd0;
  localparam cfg_index_t RegSecondWait = 3'd1;
  localparam cfg_index_t RegRow0Keys = 3'd2;
  localparam cfg_index_t RegRow1Keys = 3'd3;
  localparam cfg_index_t RegRow2Keys = 3'd4;
  localparam cfg_index_t RegRow3Keys = 3'd5;

  localparam logic [WaitBits-1:0] FirstWaitReset = 16'd20;
  localparam logic [WaitBits-1:0] SecondWaitReset = 16'd40;
  localparam logic [RowKeysBits-1:0] Row0KeysReset = 32'd792279105;
  localparam logic [RowKeysBits-1:0] Row1KeysReset = 32'd708195636;
  localparam logic [RowKeysBits-1:0] Row2KeysReset = 32'd758329905;
  localparam logic [RowKeysBits-1:0] Row3KeysReset = 32'd725430304;

  localparam logic [3:0] NoPress = 4'hF;
  localparam logic [3:0] ColPattern0 = 4'hE;
  localparam logic [3:0] ColPattern1 = 4'hD;
  localparam logic [3:0] ColPattern2 = 4'hB;
  localparam logic [3:0] AllRowsLow = 4'h0;

  typedef enum logic [3:0] {
    PH_RELEASE = 4'b0001,
    PH_FIRST   = 4'b0010,
    PH_SECOND  = 4'b0100,
    PH_SCAN    = 4'b1000
  } phase_t;

endpackage

>>> hw/rtl/mks_in_if.sv
interface mks_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] column_sense;

  modport source (output valid, output column_sense, input ready);
  modport sink (input valid, input column_sense, output ready);
endinterface

>>> hw/rtl/mks_out_if.sv
interface mks_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] row_drive;
  logic       key_valid;
  logic [7:0] key_code;
  logic [3:0] key_index;

  modport source (output valid, output row_drive, output key_valid, output key_code,
                  output key_index, input ready);
  modport sink (input valid, input row_drive, input key_valid, input key_code,
                input key_index, output ready);
endinterface

>>> hw/rtl/matrix_keypad_scanner_unit.sv
// Scanner for a 4x4 key matrix, advanced by one tick per input transaction.
// The input channel carries column_sense, the active-low column lines sampled
// under the row drive that the previous result returned. Every input
// transaction yields exactly one output transaction with row_drive for the
// next sample and, when a key is found, key_valid, key_code and key_index.
// The result is registered: it sits in the output register on the cycle
// after the input transaction. Throughput is one transaction per cycle when
// the receiver does not stall; the single output register is the only
// storage between the channels. When the receiver stalls, the held result
// stays put and the input stays ready only if it is taken in the same cycle.
// Configuration writes on cfg_we/cfg_index/cfg_data set the wait lengths and
// key character tables; the user must make them only while the scanner is
// idle, which the block does not enforce. Synchronous reset restores the
// default tables and wait lengths, empties the output register, awaits keys up.
`include "assert_macros.svh"

module matrix_keypad_scanner_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  mks_pkg::cfg_index_t         cfg_index,
  input  logic [mks_pkg::CfgDataBits-1:0] cfg_data,
  mks_in_if.sink                      in_ch,
  mks_out_if.source                   out_ch
);
  import mks_pkg::*;

  logic [WaitBits-1:0]    first_wait;
  logic [WaitBits-1:0]    second_wait;
  logic [RowKeysBits-1:0] row_keys [4];

  phase_t                 phase;
  phase_t                 phase_next;
  logic [CountBits-1:0]   wait_count;
  logic [CountBits-1:0]   wait_count_next;
  logic [1:0]             scan_row;
  logic [1:0]             scan_row_next;

  logic                   out_valid;
  logic [3:0]             row_drive;
  logic [3:0]             row_drive_next;
  logic                   key_valid;
  logic                   key_valid_next;
  logic [7:0]             key_code;
  logic [7:0]             key_code_next;
  logic [3:0]             key_index;
  logic [3:0]             key_index_next;

  logic                   in_fire;
  logic [3:0]             cols;
  logic                   pressed;
  logic [WaitBits-1:0]    wait_limit;
  logic [CmpBits-1:0]     count_plus;
  logic                   wait_hit;
  logic [1:0]             col;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_wait  <= FirstWaitReset;
      second_wait <= SecondWaitReset;
      row_keys[0] <= Row0KeysReset;
      row_keys[1] <= Row1KeysReset;
      row_keys[2] <= Row2KeysReset;
      row_keys[3] <= Row3KeysReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegFirstWait:  first_wait  <= cfg_data[WaitBits-1:0];
        RegSecondWait: second_wait <= cfg_data[WaitBits-1:0];
        RegRow0Keys:   row_keys[0] <= cfg_data[RowKeysBits-1:0];
        RegRow1Keys:   row_keys[1] <= cfg_data[RowKeysBits-1:0];
        RegRow2Keys:   row_keys[2] <= cfg_data[RowKeysBits-1:0];
        RegRow3Keys:   row_keys[3] <= cfg_data[RowKeysBits-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cols = in_ch.column_sense;
  assign pressed = (cols != NoPress);

  assign wait_limit = (phase == PH_SECOND) ? second_wait : first_wait;
  assign count_plus = CmpBits'(wait_count) + CmpBits'(1);
  assign wait_hit = (count_plus >= CmpBits'(wait_limit)) || (wait_count == '1);

  always_comb begin
    unique case (cols)
      ColPattern0: col = 2'd0;
      ColPattern1: col = 2'd1;
      ColPattern2: col = 2'd2;
      default:     col = 2'd3;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    wait_count_next = wait_count;
    scan_row_next   = scan_row;
    row_drive_next  = AllRowsLow;
    key_valid_next  = 1'b0;
    key_code_next   = '0;
    key_index_next  = '0;
    unique case (phase)
      PH_RELEASE: begin
        if (!pressed) begin
          phase_next      = PH_FIRST;
          wait_count_next = '0;
        end
      end
      PH_FIRST: begin
        wait_count_next = wait_hit ? '0 : wait_count + CountBits'(1);
        if (wait_hit && pressed) begin
          phase_next = PH_SECOND;
        end
      end
      PH_SECOND: begin
        wait_count_next = wait_hit ? '0 : wait_count + CountBits'(1);
        if (wait_hit) begin
          if (pressed) begin
            phase_next     = PH_SCAN;
            scan_row_next  = 2'd0;
            row_drive_next = ~(4'b0001);
          end else begin
            phase_next = PH_FIRST;
          end
        end
      end
      PH_SCAN: begin
        if (pressed) begin
          key_valid_next = 1'b1;
          key_code_next  = row_keys[scan_row][{col, 3'b000} +: 8];
          key_index_next = {scan_row, col};
          phase_next     = PH_RELEASE;
          scan_row_next  = 2'd0;
        end else if (scan_row == 2'd3) begin
          phase_next    = PH_RELEASE;
          scan_row_next = 2'd0;
        end else begin
          scan_row_next  = scan_row + 2'd1;
          row_drive_next = ~(4'b0001 << (scan_row + 2'd1));
        end
      end
      default: begin
        phase_next = PH_RELEASE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_RELEASE;
      wait_count <= '0;
      scan_row   <= 2'd0;
      out_valid  <= 1'b0;
    end else begin
      if (in_fire) begin
        phase      <= phase_next;
        wait_count <= wait_count_next;
        scan_row   <= scan_row_next;
        out_valid  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_drive <= row_drive_next;
      key_valid <= key_valid_next;
      key_code  <= key_code_next;
      key_index <= key_index_next;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.row_drive = row_drive;
  assign out_ch.key_valid = key_valid;
  assign out_ch.key_code  = key_code;
  assign out_ch.key_index = key_index;

  `ASSERT_CLK(a_key_drives_all_low, (out_valid && key_valid) |-> (row_drive == AllRowsLow),
              "A reported key must come with all rows driven low.")
  `ASSERT_CLK(a_no_key_zero_fields,
              (out_valid && !key_valid) |-> (key_code == 8'd0 && key_index == 4'd0),
              "Key fields must be zero when no key is reported.")
  `ASSERT_CLK(a_key_returns_release, (in_fire && phase == PH_SCAN && pressed) |=>
              (phase == PH_RELEASE && key_valid),
              "A found key must report and return to the release wait.")
endmodule
